>>> hdl/bust_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bust_pkg
// Shared types, widths and codes for the bounded unique set table.
// ----------------------------------------------------------------------------
package bust_pkg;

	localparam int FUNC_W  = 2;
	localparam int VAL_W   = 32;
	localparam int IDX_W   = 4;
	localparam int STAT_W  = 3;
	localparam int COUNT_W = 5;
	localparam int LIM_W   = 5;

	// built capacity; the port widths hold it to 1..16
	localparam int CAPACITY_DEF = 16;

	localparam logic [LIM_W-1:0] MAX_ENTRIES_RST = LIM_W'(10);

	typedef enum logic [FUNC_W-1:0] {
		OP_QUERY  = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 3'd0,
		ST_PRESENT = 3'd1,
		ST_FULL    = 3'd2,
		ST_ABSENT  = 3'd3,
		ST_RANGE   = 3'd4
	} status_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic             ins_en;
		logic             rem_en;
		logic [VAL_W-1:0] value;
	} cell_ctl_t;

endpackage

>>> hdl/bust_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bust_in_if
// Request channel: operation, value and index with valid/ready.
// ----------------------------------------------------------------------------
interface bust_in_if
	import bust_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic signed [VAL_W-1:0]  value;
	logic [IDX_W-1:0]         index;

	modport source (output valid, output func, output value, output index, input ready);
	modport sink   (input valid, input func, input value, input index, output ready);
endinterface

>>> hdl/bust_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bust_out_if
// Response channel: status, read data, count and flags with valid/ready.
// ----------------------------------------------------------------------------
interface bust_out_if
	import bust_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [VAL_W-1:0]  read_value;
	logic [COUNT_W-1:0]       entry_count;
	logic                     is_empty;
	logic                     is_full;

	modport source (output valid, output status, output read_value, output entry_count,
		output is_empty, output is_full, input ready);
	modport sink   (input valid, input status, input read_value, input entry_count,
		input is_empty, input is_full, output ready);
endinterface

>>> hdl/bounded_unique_set_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_unique_set_table_top
// Bounded set of signed 32-bit values held as a packed row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request word: func (query, insert, remove, read), value
//   and index. rsp carries one response word per request: status, read_value,
//   entry_count, is_empty and is_full as they stand after the operation.
//   cfg_we/cfg_wdata write max_entries; write it only while no request is
//   in flight.
// Timing:
//   An accepted request completes at its edge: every cell compares its entry
//   with the request value at once and the hit ripples up the row, so inserts
//   land at the tail and removes shift all upper cells down in the same edge.
//   The response appears in the output register on the next cycle, and one
//   word per cycle is sustained while rsp.ready stays high.
// Reset:
//   arst_n clears the count, all cell occupancy bits and the output valid,
//   and sets max_entries to 10. Entry data is not reset.
// Stall:
//   While rsp.ready is low and a word is held, req.ready is low; the held
//   word stays stable until taken.
// CAPACITY ranges from 1 to 16.
// ----------------------------------------------------------------------------
module bounded_unique_set_table_top
	import bust_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
)(
	input  logic              clk,
	input  logic              arst_n,
	bust_in_if.sink           req,
	bust_out_if.source        rsp,
	input  logic              cfg_we,
	input  logic [LIM_W-1:0]  cfg_wdata
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [LIM_W-1:0]  max_entries_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic              rsp_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [VAL_W-1:0]  read_value_q;
	logic [COUNT_W-1:0] entry_count_q;
	logic              is_empty_q;
	logic              is_full_q;

	logic              accept;
	op_t               op;
	logic [LIM_W-1:0]  lim;
	logic [COUNT_W-1:0] cnt_ext;
	logic [COUNT_W-1:0] cnt_nxt_ext;
	logic              full_now;
	logic              any_hit;
	logic              in_range;
	status_t           status_c;
	logic [VAL_W-1:0]  rd_c;
	cell_ctl_t         ctl;

	logic [VAL_W-1:0]  entry_w [CAPACITY];
	logic              occ_w   [CAPACITY];
	logic              hit_w   [CAPACITY+1];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign op        = op_t'(req.func);

	assign lim      = (max_entries_q > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : max_entries_q;
	assign cnt_ext  = COUNT_W'(count_q);
	assign full_now = cnt_ext >= COUNT_W'(lim);
	assign any_hit  = hit_w[CAPACITY];
	assign in_range = (COUNT_W'(req.index) < cnt_ext) && (int'(req.index) < CAPACITY);

	// read mux over the cell row
	always_comb begin
		rd_c = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (int'(req.index) == i) begin
				rd_c = entry_w[i];
			end
		end
	end

	always_comb begin
		status_c   = ST_OK;
		count_nxt  = count_q;
		ctl.ins_en = 1'b0;
		ctl.rem_en = 1'b0;
		ctl.value  = req.value;
		case (op)
			OP_QUERY: begin
				if (!any_hit) begin
					status_c = ST_ABSENT;
				end
			end
			OP_INSERT: begin
				if (full_now) begin
					status_c = ST_FULL;
				end else if (any_hit) begin
					status_c = ST_PRESENT;
				end else if (int'(count_q) < CAPACITY) begin
					ctl.ins_en = accept;
					count_nxt  = count_q + CNT_W'(1);
				end else begin
					status_c = ST_FULL;
				end
			end
			OP_REMOVE: begin
				if (any_hit) begin
					ctl.rem_en = accept;
					count_nxt  = count_q - CNT_W'(1);
				end else begin
					status_c = ST_ABSENT;
				end
			end
			default: begin
				if (!in_range) begin
					status_c = ST_RANGE;
				end
			end
		endcase
	end

	assign cnt_nxt_ext = COUNT_W'(count_nxt);

	assign hit_w[0] = 1'b0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [VAL_W-1:0] nxt_e;
		logic             nxt_o;
		logic             prv_o;

		if (g == CAPACITY - 1) begin : g_last
			assign nxt_e = '0;
			assign nxt_o = 1'b0;
		end else begin : g_mid
			assign nxt_e = entry_w[g+1];
			assign nxt_o = occ_w[g+1];
		end

		if (g == 0) begin : g_first
			assign prv_o = 1'b1;
		end else begin : g_upper
			assign prv_o = occ_w[g-1];
		end

		bust_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_occ   (prv_o),
			.hit_in     (hit_w[g]),
			.next_entry (nxt_e),
			.next_occ   (nxt_o),
			.hit_out    (hit_w[g+1]),
			.entry      (entry_w[g]),
			.occ        (occ_w[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
			count_q       <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_entries_q <= cfg_wdata;
			end
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold the response payload until taken
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_c;
			read_value_q  <= (op == OP_READ && in_range) ? rd_c : '0;
			entry_count_q <= cnt_nxt_ext;
			is_empty_q    <= (cnt_nxt_ext == '0);
			is_full_q     <= (cnt_nxt_ext >= COUNT_W'(lim));
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.entry_count = entry_count_q;
	assign rsp.is_empty    = is_empty_q;
	assign rsp.is_full     = is_full_q;

endmodule

>>> hdl/bust_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bust_cell
// One slot of the packed list: holds an entry, compares it with the request
// value, loads on insert at the tail and shifts down on remove.
// ----------------------------------------------------------------------------
module bust_cell
	import bust_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic             prev_occ,   // slot below is held
	input  logic             hit_in,     // match somewhere below
	input  logic [VAL_W-1:0] next_entry,
	input  logic             next_occ,
	output logic             hit_out,
	output logic [VAL_W-1:0] entry,
	output logic             occ
);

	logic [VAL_W-1:0] entry_q;
	logic             occ_q;
	logic             match;
	logic             shift;
	logic             load;

	assign match   = occ_q && (entry_q == ctl.value);
	assign hit_out = hit_in || match;
	// a removed slot and every slot above it take the neighbor's word
	assign shift   = ctl.rem_en && hit_out;
	// insert lands in the first free slot
	assign load    = ctl.ins_en && !occ_q && prev_occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (shift) begin
			occ_q <= next_occ;
		end else if (load) begin
			occ_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= next_entry;
		end else if (load) begin
			entry_q <= ctl.value;
		end
	end

	assign entry = entry_q;
	assign occ   = occ_q;

endmodule

>>> hdl/bust_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bust_checker
// Port-level checks on the bounded unique set table, bound to the top level.
// ----------------------------------------------------------------------------
module bust_checker
	import bust_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [STAT_W-1:0]  status,
	input logic [VAL_W-1:0]   read_value,
	input logic [COUNT_W-1:0] entry_count,
	input logic               is_empty
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_value)
			&& $stable(entry_count))
		else $error("response word changed while stalled");

	a_one_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted request produced no response word");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_count == '0)))
		else $error("empty flag disagrees with entry count");

	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (read_value == '0))
		else $error("read data nonzero on failed operation");

	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_RANGE) && (entry_count <= COUNT_W'(CAPACITY_DEF)))
		else $error("status or count out of range");

endmodule

bind bounded_unique_set_table_top bust_checker u_bust_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.status      (rsp.status),
	.read_value  (rsp.read_value),
	.entry_count (rsp.entry_count),
	.is_empty    (rsp.is_empty)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded unique set table.
// A software copy of the set tracks every accepted request and predicts the
// status, read data, count and flags of each response. Requests arrive in
// bursts with random gaps, and the response side stalls in changing patterns.
// The max_entries limit is changed between phases, including zero and values
// above the capacity.
// ----------------------------------------------------------------------------
module tb_top;
	import bust_pkg::*;

	localparam int CAP         = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL_N      = 20;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_ITEMS = 90;

	typedef struct {
		logic [STAT_W-1:0]       status;
		logic signed [VAL_W-1:0] read_value;
		logic [COUNT_W-1:0]      entry_count;
		logic                    is_empty;
		logic                    is_full;
	} set_reply_t;

	class membership_tracker;
		logic signed [VAL_W-1:0] members[CAP];
		int unsigned             held;
		logic [LIM_W-1:0]        max_entries;
		set_reply_t              expected_replies[$];
		int unsigned             mismatches;
		int unsigned             replies_checked;
		int unsigned             ops_seen[4];
		int unsigned             status_seen[5];

		function new();
			held = 0;
			max_entries = MAX_ENTRIES_RST;
			mismatches = 0;
			replies_checked = 0;
			foreach (ops_seen[i]) ops_seen[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function int unsigned limit();
			return (max_entries > CAP) ? CAP : max_entries;
		endfunction

		// position of the first match, or held when absent
		function int unsigned slot_of(logic signed [VAL_W-1:0] v);
			for (int unsigned i = 0; i < held; i++) begin
				if (members[i] == v) return i;
			end
			return held;
		endfunction

		function void note_request(op_t f, logic signed [VAL_W-1:0] v, logic [IDX_W-1:0] ix);
			set_reply_t   r;
			int unsigned  lim;
			int unsigned  pos;
			status_t      st;
			lim = limit();
			st = ST_OK;
			r.read_value = '0;
			case (f)
				OP_QUERY: begin
					if (slot_of(v) >= held) st = ST_ABSENT;
				end
				OP_INSERT: begin
					if (held >= lim) st = ST_FULL;
					else if (slot_of(v) < held) st = ST_PRESENT;
					else if (held < CAP) begin
						members[held] = v;
						held++;
					end else st = ST_FULL;
				end
				OP_REMOVE: begin
					pos = slot_of(v);
					if (pos < held) begin
						// close the gap
						for (int unsigned i = pos + 1; i < held; i++) members[i-1] = members[i];
						held--;
					end else st = ST_ABSENT;
				end
				default: begin
					if (ix < held) r.read_value = members[ix];
					else st = ST_RANGE;
				end
			endcase
			r.status = st;
			r.entry_count = COUNT_W'(held);
			r.is_empty = (held == 0);
			r.is_full = (held >= lim);
			ops_seen[f]++;
			status_seen[st]++;
			expected_replies.push_back(r);
		endfunction

		function void check_reply(set_reply_t got);
			set_reply_t want;
			if (expected_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected response word, status %0d count %0d",
						$time, got.status, got.entry_count);
				return;
			end
			want = expected_replies.pop_front();
			replies_checked++;
			if (got.status !== want.status || got.read_value !== want.read_value ||
					got.entry_count !== want.entry_count || got.is_empty !== want.is_empty ||
					got.is_full !== want.is_full) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: response mismatch on word %0d", $time, replies_checked);
					$display("  expected status %0d read %h count %0d empty %b full %b",
						want.status, want.read_value, want.entry_count, want.is_empty,
						want.is_full);
					$display("  actual   status %0d read %h count %0d empty %b full %b",
						got.status, got.read_value, got.entry_count, got.is_empty,
						got.is_full);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [LIM_W-1:0]    cfg_wdata;
	int unsigned         cycles;
	int unsigned         limits_used;
	logic signed [VAL_W-1:0] value_pool[POOL_N];
	membership_tracker   sb;

	bust_in_if  req_if();
	bust_out_if rsp_if();

	bounded_unique_set_table_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if.sink),
		.rsp       (rsp_if.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				sb.expected_replies.size());
			$display("[bounded_unique_set_table_top] ERROR");
			$finish;
		end
	end

	// take response words
	always @(posedge clk) begin
		set_reply_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got.status = rsp_if.status;
			got.read_value = rsp_if.read_value;
			got.entry_count = rsp_if.entry_count;
			got.is_empty = rsp_if.is_empty;
			got.is_full = rsp_if.is_full;
			sb.check_reply(got);
		end
	end

	// response-side stall pattern: the mode is redrawn at random after each run
	initial begin
		int mode;
		int left;
		int tick;
		mode = 0;
		left = 0;
		tick = 0;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 150);
			end
			left--;
			tick++;
			case (mode)
				0: rsp_if.ready = 1'b1;
				1: rsp_if.ready = ($urandom_range(0, 2) != 0);
				2: rsp_if.ready = (tick % 4 == 0);
				default: rsp_if.ready = ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// present one word and hold it until taken; valid stays high afterwards
	task automatic send_request(op_t f, logic signed [VAL_W-1:0] v, logic [IDX_W-1:0] ix);
		req_if.valid = 1'b1;
		req_if.func = f;
		req_if.value = v;
		req_if.index = ix;
		do @(posedge clk); while (!req_if.ready);
		sb.note_request(f, v, ix);
		@(negedge clk);
	endtask

	task automatic idle_for(int n);
		req_if.valid = 1'b0;
		req_if.value = $urandom;
		req_if.index = IDX_W'($urandom);
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_drain();
		req_if.valid = 1'b0;
		while (sb.expected_replies.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(logic [LIM_W-1:0] lim);
		wait_drain();
		cfg_we = 1'b1;
		cfg_wdata = lim;
		@(posedge clk);
		sb.max_entries = lim;
		limits_used++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, POOL_N - 1)];
		return $urandom;
	endfunction

	function automatic op_t pick_op(int ins_w, int rem_w);
		int r;
		r = $urandom_range(0, 99);
		if (r < ins_w) return OP_INSERT;
		if (r < ins_w + rem_w) return OP_REMOVE;
		if (r < ins_w + rem_w + (100 - ins_w - rem_w) / 2) return OP_QUERY;
		return OP_READ;
	endfunction

	initial begin
		logic [LIM_W-1:0] phase_limits[RAND_PHASES];
		int               ins_w;
		int               rem_w;
		int               sent;
		int               burst;
		op_t              f;
		logic [IDX_W-1:0] ix;

		phase_limits = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd5, 5'd10, 5'd2, 5'd16, 5'd8};
		sb = new();
		cycles = 0;
		limits_used = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.func = OP_QUERY;
		req_if.value = '0;
		req_if.index = '0;

		value_pool[0] = 32'sh8000_0000;
		value_pool[1] = 32'sh7fff_ffff;
		value_pool[2] = 32'sh0;
		value_pool[3] = -32'sd1;
		value_pool[4] = 32'sd1;
		for (int i = 5; i < POOL_N; i++) value_pool[i] = $urandom;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: empty set, extremes, duplicates, shift on remove
		send_request(OP_READ, $urandom, 4'd0);
		send_request(OP_QUERY, 32'sh0, IDX_W'($urandom));
		send_request(OP_REMOVE, 32'sd5, IDX_W'($urandom));
		send_request(OP_INSERT, 32'sh8000_0000, IDX_W'($urandom));
		send_request(OP_INSERT, 32'sh7fff_ffff, IDX_W'($urandom));
		send_request(OP_INSERT, 32'sh0, IDX_W'($urandom));
		send_request(OP_INSERT, -32'sd1, IDX_W'($urandom));
		send_request(OP_INSERT, 32'sh7fff_ffff, IDX_W'($urandom));
		send_request(OP_QUERY, 32'sh8000_0000, IDX_W'($urandom));
		send_request(OP_READ, $urandom, 4'd3);
		send_request(OP_READ, $urandom, 4'd15);
		send_request(OP_REMOVE, 32'sh7fff_ffff, IDX_W'($urandom));
		send_request(OP_READ, $urandom, 4'd1);
		send_request(OP_READ, $urandom, 4'd2);
		send_request(OP_READ, $urandom, 4'd3);

		// limit below the count: full even for a present value
		write_limit(5'd2);
		send_request(OP_INSERT, 32'sh0, IDX_W'($urandom));
		send_request(OP_INSERT, 32'sd55, IDX_W'($urandom));
		send_request(OP_REMOVE, 32'sh8000_0000, IDX_W'($urandom));
		send_request(OP_REMOVE, -32'sd1, IDX_W'($urandom));
		send_request(OP_INSERT, 32'sd77, IDX_W'($urandom));

		// zero limit refuses every insert
		write_limit(5'd0);
		send_request(OP_INSERT, 32'sd9, IDX_W'($urandom));
		send_request(OP_QUERY, 32'sd77, IDX_W'($urandom));
		send_request(OP_READ, $urandom, 4'd1);

		for (int p = 0; p < RAND_PHASES; p++) begin
			write_limit(phase_limits[p]);
			ins_w = $urandom_range(25, 60);
			rem_w = $urandom_range(10, 35);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 20);
				for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
					f = pick_op(ins_w, rem_w);
					if ($urandom_range(0, 3) != 0 && sb.held > 0)
						ix = IDX_W'($urandom_range(0, sb.held - 1));
					else
						ix = IDX_W'($urandom);
					send_request(f, pick_value(), ix);
					sent++;
				end
				if ($urandom_range(0, 14) == 0) wait_drain();
				else if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 6));
			end
		end

		wait_drain();
		repeat (8) @(negedge clk);
		$display("checked %0d responses over %0d limit settings; ops q/i/r/rd %0d/%0d/%0d/%0d",
			sb.replies_checked, limits_used, sb.ops_seen[OP_QUERY], sb.ops_seen[OP_INSERT],
			sb.ops_seen[OP_REMOVE], sb.ops_seen[OP_READ]);
		$display("statuses ok/present/full/absent/range %0d/%0d/%0d/%0d/%0d, mismatches %0d",
			sb.status_seen[ST_OK], sb.status_seen[ST_PRESENT], sb.status_seen[ST_FULL],
			sb.status_seen[ST_ABSENT], sb.status_seen[ST_RANGE], sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_replies.size() == 0) begin
			$display("[bounded_unique_set_table_top] OK");
		end else begin
			$display("[bounded_unique_set_table_top] ERROR");
		end
		$finish;
	end

endmodule
